### hw/rtl/srdc_pkg.sv
// shared types, constants and helpers for the signed radix digit converter
`timescale 1ns / 1ps

package srdc_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int DECIMAL_DIGITS = 10;

   localparam int BIN_DIGITS = VALUE_WIDTH;
   localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int BCD_W      = 4 * DECIMAL_DIGITS;

   // working register holds the widest left-aligned digit string
   localparam int WORK_A = (3 * OCT_DIGITS > 4 * HEX_DIGITS) ? 3 * OCT_DIGITS : 4 * HEX_DIGITS;
   localparam int WORK_B = (WORK_A > VALUE_WIDTH) ? WORK_A : VALUE_WIDTH;
   localparam int WORK_W = (WORK_B > BCD_W) ? WORK_B : BCD_W;

   localparam int BIN_SHIFT = WORK_W - BIN_DIGITS;
   localparam int OCT_SHIFT = WORK_W - 3 * OCT_DIGITS;
   localparam int HEX_SHIFT = WORK_W - 4 * HEX_DIGITS;
   localparam int BCD_SHIFT = WORK_W - BCD_W;

   localparam int MAX_DIGITS = (BIN_DIGITS > DECIMAL_DIGITS) ? BIN_DIGITS : DECIMAL_DIGITS;
   localparam int CNT_W      = $clog2(MAX_DIGITS);
   localparam int BITCNT_W   = $clog2(VALUE_WIDTH);

   localparam logic [CNT_W-1:0] BIN_LAST = CNT_W'(BIN_DIGITS - 1);
   localparam logic [CNT_W-1:0] OCT_LAST = CNT_W'(OCT_DIGITS - 1);
   localparam logic [CNT_W-1:0] HEX_LAST = CNT_W'(HEX_DIGITS - 1);
   localparam logic [CNT_W-1:0] BCD_LAST = CNT_W'(DECIMAL_DIGITS - 1);
   localparam logic [BITCNT_W-1:0] DABBLE_LAST = BITCNT_W'(VALUE_WIDTH - 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [2:0] CMD_BIN = 3'd0;
   localparam logic [2:0] CMD_OCT = 3'd1;
   localparam logic [2:0] CMD_HEX = 3'd2;
   localparam logic [2:0] CMD_BCD = 3'd3;
   localparam logic [2:0] CMD_ALL = 3'd4;

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_BCD = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SKIP,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic                   all_radix;
      radix_type              kind;
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
   } queue_entry_type;

   // double dabble correction: add 3 to every digit of 5 or more
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int i = 0; i < DECIMAL_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

### hw/rtl/srdc_front.sv
// front end: takes items, splits sign and magnitude, drops unused commands
`timescale 1ns / 1ps

module srdc_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_cmd,
   input  logic signed [31:0]        req_value,
   input  logic                      q_full,
   output logic                      q_push,
   output srdc_pkg::queue_entry_type q_entry
);
   import srdc_pkg::*;

   logic [VALUE_WIDTH-1:0] raw;
   logic                   neg;
   logic                   accept;

   assign raw    = req_value[VALUE_WIDTH-1:0];
   assign neg    = raw[VALUE_WIDTH-1];
   assign accept = req_valid && !q_full;

   assign req_stall = q_full;
   assign q_push    = accept && (req_cmd <= CMD_ALL);

   always_comb begin
      q_entry.all_radix = (req_cmd == CMD_ALL);
      q_entry.neg       = neg;
      q_entry.mag       = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
      case (req_cmd)
         CMD_BIN: q_entry.kind = RADIX_BIN;
         CMD_OCT: q_entry.kind = RADIX_OCT;
         CMD_HEX: q_entry.kind = RADIX_HEX;
         CMD_BCD: q_entry.kind = RADIX_BCD;
         default: q_entry.kind = RADIX_BIN;
      endcase
   end

endmodule

### hw/rtl/srdc_queue.sv
// short item queue between front end and converter
`timescale 1ns / 1ps

module srdc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  srdc_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output srdc_pkg::queue_entry_type head_entry
);
   import srdc_pkg::*;

   queue_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/srdc_back.sv
// converter back end: double dabble, leading zero skip and digit output
`timescale 1ns / 1ps

module srdc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  srdc_pkg::queue_entry_type q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_digit,
   output logic [1:0]                rsp_radix_kind,
   output logic                      rsp_negative,
   output logic                      rsp_number_end,
   output logic                      rsp_last
);
   import srdc_pkg::*;

   localparam int TOP = WORK_W - 1;

   back_state_type         state_ff, state_in;
   radix_type              kind_ff, kind_in;
   logic                   all_ff, all_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [VALUE_WIDTH-1:0] dab_ff, dab_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   ovf_ff, ovf_in;
   logic [BITCNT_W-1:0]    bitcnt_ff, bitcnt_in;
   logic [WORK_W-1:0]      work_ff, work_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   first_ff, first_in;

   logic                   start_idle, start_next, out_take, number_done, more_numbers;
   radix_type              start_kind, next_kind;
   logic [VALUE_WIDTH-1:0] start_mag;
   logic [BCD_W-1:0]       bcd_adj, bcd_shift;
   logic [3:0]             top_digit;
   logic [WORK_W-1:0]      work_step;
   logic                   skip_more;

   // digit at the top of the working register and the one-digit advance
   always_comb begin
      case (kind_ff)
         RADIX_BIN: begin
            top_digit = {3'b000, work_ff[TOP]};
            work_step = work_ff << 1;
         end
         RADIX_OCT: begin
            top_digit = {1'b0, work_ff[TOP -: 3]};
            work_step = work_ff << 3;
         end
         default: begin
            top_digit = work_ff[TOP -: 4];
            work_step = work_ff << 4;
         end
      endcase
   end

   assign bcd_adj   = bcd_adjust(bcd_ff);
   assign bcd_shift = {bcd_adj[BCD_W-2:0], dab_ff[VALUE_WIDTH-1]};

   assign out_take     = (state_ff == ST_EMIT) && !rsp_stall;
   assign number_done  = (cnt_ff == '0);
   assign more_numbers = all_ff && (kind_ff != RADIX_BCD);
   assign next_kind    = radix_type'(kind_ff + 2'd1);
   assign start_idle   = (state_ff == ST_IDLE) && q_valid;
   assign start_next   = out_take && number_done && more_numbers;
   assign start_kind   = start_idle ? q_entry.kind : next_kind;
   assign start_mag    = start_idle ? q_entry.mag : mag_ff;
   // a truncated decimal number keeps its leading zeros
   assign skip_more    = (top_digit == 4'd0) && !number_done &&
                         !((kind_ff == RADIX_BCD) && ovf_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_entry.kind == RADIX_BCD) ? ST_DABBLE : ST_SKIP;
            end
         end
         ST_DABBLE: begin
            if (bitcnt_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!skip_more) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_take && number_done) begin
               if (more_numbers) begin
                  state_in = (next_kind == RADIX_BCD) ? ST_DABBLE : ST_SKIP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop          = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         ST_IDLE: q_pop     = q_valid;
         ST_EMIT: rsp_valid = 1'b1;
         default: ;
      endcase
      rsp_digit      = top_digit;
      rsp_radix_kind = kind_ff;
      rsp_negative   = neg_ff && first_ff;
      rsp_number_end = number_done;
      rsp_last       = number_done && !more_numbers;
   end

   // datapath
   always_comb begin
      kind_in   = kind_ff;
      all_in    = all_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      dab_in    = dab_ff;
      bcd_in    = bcd_ff;
      ovf_in    = ovf_ff;
      bitcnt_in = bitcnt_ff;
      work_in   = work_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;

      if (start_idle) begin
         all_in = q_entry.all_radix;
         neg_in = q_entry.neg;
         mag_in = q_entry.mag;
      end

      if (state_ff == ST_DABBLE) begin
         bcd_in    = bcd_shift;
         ovf_in    = ovf_ff | bcd_adj[BCD_W-1];
         dab_in    = dab_ff << 1;
         bitcnt_in = bitcnt_ff - BITCNT_W'(1);
         if (bitcnt_ff == '0) begin
            work_in = WORK_W'(bcd_shift) << BCD_SHIFT;
            cnt_in  = BCD_LAST;
         end
      end

      if (state_ff == ST_SKIP) begin
         if (skip_more) begin
            work_in = work_step;
            cnt_in  = cnt_ff - CNT_W'(1);
         end else begin
            first_in = 1'b1;
         end
      end

      if (out_take) begin
         work_in  = work_step;
         cnt_in   = cnt_ff - CNT_W'(1);
         first_in = 1'b0;
      end

      if (start_idle || start_next) begin
         kind_in = start_kind;
         case (start_kind)
            RADIX_BIN: begin
               work_in = WORK_W'(start_mag) << BIN_SHIFT;
               cnt_in  = BIN_LAST;
            end
            RADIX_OCT: begin
               work_in = WORK_W'(start_mag) << OCT_SHIFT;
               cnt_in  = OCT_LAST;
            end
            RADIX_HEX: begin
               work_in = WORK_W'(start_mag) << HEX_SHIFT;
               cnt_in  = HEX_LAST;
            end
            default: begin
               bcd_in    = '0;
               ovf_in    = 1'b0;
               dab_in    = start_mag;
               bitcnt_in = DABBLE_LAST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      all_ff    <= all_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      dab_ff    <= dab_in;
      bcd_ff    <= bcd_in;
      ovf_ff    <= ovf_in;
      bitcnt_ff <= bitcnt_in;
      work_ff   <= work_in;
      cnt_ff    <= cnt_in;
      first_ff  <= first_in;
   end

endmodule

### hw/rtl/signed_radix_digit_converter_core.sv
// top level of the signed radix digit converter
`timescale 1ns / 1ps

// path to the first digit: the accepted item is written into the queue, the back end
//   pops it in idle, runs the double dabble loop for decimal, then skips leading zero
//   digit positions before it emits; one digit position per cycle in skip and emit,
//   emission only while rsp_stall is low; the double dabble loop shifts in every bit of
//   the magnitude; items pass through idle; all-radix items run all four radices in turn
// the converter loop in the back end sets the rate; the front takes up to two items ahead
// reset is synchronous, active high; it clears the queue and the converter state
// digit results leave at one per cycle in the emit phase while rsp_stall is low
module signed_radix_digit_converter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_digit,
   output logic [1:0]         rsp_radix_kind,
   output logic               rsp_negative,
   output logic               rsp_number_end,
   output logic               rsp_last
);
   import srdc_pkg::*;

   // front to queue
   logic            q_full;
   logic            q_push;
   queue_entry_type q_push_entry;

   // queue to back end
   logic            q_head_valid;
   logic            q_pop;
   queue_entry_type q_head_entry;

   // sign and magnitude split, unused commands taken and dropped
   srdc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   // small queue so the front keeps taking items while digits drain
   srdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   // per number: optional double dabble, leading zero skip, then digit output
   srdc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_head_valid),
      .q_entry        (q_head_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit      (rsp_digit),
      .rsp_radix_kind (rsp_radix_kind),
      .rsp_negative   (rsp_negative),
      .rsp_number_end (rsp_number_end),
      .rsp_last       (rsp_last)
   );

endmodule
